// ----- rtl/core/pit3d_pkg.sv -----
// ----------------------------------------------------------------------------
// pit3d_pkg: shared constant for the 3-D point-in-triangle test
// Holds the default coordinate width used by the query interface and all modules.
// ----------------------------------------------------------------------------
package pit3d_pkg;

	// default width of one signed coordinate
	localparam int COORD_BITS_DEF = 16;

endpackage

// ----- rtl/core/pit3d_qry_if.sv -----
// ----------------------------------------------------------------------------
// pit3d_qry_if: query channel
// Valid/ready channel that carries three triangle corners and one query point.
// ----------------------------------------------------------------------------
interface pit3d_qry_if #(
	parameter int COORD_BITS = pit3d_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_x;
	logic signed [COORD_BITS-1:0] a_y;
	logic signed [COORD_BITS-1:0] a_z;
	logic signed [COORD_BITS-1:0] b_x;
	logic signed [COORD_BITS-1:0] b_y;
	logic signed [COORD_BITS-1:0] b_z;
	logic signed [COORD_BITS-1:0] c_x;
	logic signed [COORD_BITS-1:0] c_y;
	logic signed [COORD_BITS-1:0] c_z;
	logic signed [COORD_BITS-1:0] q_x;
	logic signed [COORD_BITS-1:0] q_y;
	logic signed [COORD_BITS-1:0] q_z;

	modport source (
		output valid,
		input  ready,
		output a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, q_x, q_y, q_z
	);

	modport sink (
		input  valid,
		output ready,
		input  a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, q_x, q_y, q_z
	);
endinterface

// ----- rtl/core/pit3d_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pit3d_rsp_if: response channel
// Valid/ready channel that carries the one-bit inside flag.
// ----------------------------------------------------------------------------
interface pit3d_rsp_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (
		output valid,
		input  ready,
		output inside_res
	);

	modport sink (
		input  valid,
		output ready,
		input  inside_res
	);
endinterface

// ----- rtl/core/point_in_triangle_3d_test.sv -----
// ----------------------------------------------------------------------------
// point_in_triangle_3d_test: strict point-in-triangle test for 3-D points
// Pipeline: two register stages; the input register (_s1) captures the query
//   and the result register (_s2) holds the answer that drives the response.
// Throughput: one query transaction per cycle while rsp.ready is not held low,
//   set by the single evaluation pass between the _s1 and _s2 registers.
// Reset: arst_n clears both valid bits at once; payload registers are not reset.
// ----------------------------------------------------------------------------
module point_in_triangle_3d_test #(
	parameter int COORD_BITS = pit3d_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pit3d_qry_if.sink   qry,
	pit3d_rsp_if.source rsp
);
	import pit3d_pkg::*;

	// Stage 1 holds the captured query; stage 2 holds the finished answer.
	logic                         vld_s1;
	logic signed [COORD_BITS-1:0] a_s1 [3];
	logic signed [COORD_BITS-1:0] b_s1 [3];
	logic signed [COORD_BITS-1:0] c_s1 [3];
	logic signed [COORD_BITS-1:0] q_s1 [3];
	logic                         vld_s2;
	logic                         inside_s2;

	logic inside_c;
	logic s2_free;
	logic s1_adv;
	logic qry_take;

	// The result register frees up when empty or when its transaction leaves
	// this cycle; stage 1 advances into it when it holds a query and it is free.
	assign s2_free  = !vld_s2 || rsp.ready;
	assign s1_adv   = vld_s1 && s2_free;
	assign qry.ready = !vld_s1 || s2_free;
	assign qry_take = qry.valid && qry.ready;

	// Capture the query payload on every accepted transaction.
	always_ff @(posedge clk) begin
		if (qry_take) begin
			a_s1[0] <= qry.a_x;
			a_s1[1] <= qry.a_y;
			a_s1[2] <= qry.a_z;
			b_s1[0] <= qry.b_x;
			b_s1[1] <= qry.b_y;
			b_s1[2] <= qry.b_z;
			c_s1[0] <= qry.c_x;
			c_s1[1] <= qry.c_y;
			c_s1[2] <= qry.c_z;
			q_s1[0] <= qry.q_x;
			q_s1[1] <= qry.q_y;
			q_s1[2] <= qry.q_z;
		end
	end

	// Hold stage 1 valid while its query waits for the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (qry.ready) begin
			vld_s1 <= qry.valid;
		end
	end

	// One combinational pass: four areas, three segment checks, final select.
	pit3d_eval #(.COORD_BITS(COORD_BITS)) u_eval (
		.a      (a_s1),
		.b      (b_s1),
		.c      (c_s1),
		.q      (q_s1),
		.in_tri (inside_c)
	);

	// Load the answer when stage 1 advances; drop valid once taken.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			inside_s2 <= inside_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= vld_s1;
		end
	end

	assign rsp.valid      = vld_s2;
	assign rsp.inside_res = inside_s2;
endmodule

// ----- rtl/core/pit3d_area.sv -----
// ----------------------------------------------------------------------------
// pit3d_area: doubled triangle area against (1,1,1)
// Magnitude of det[u-w; v-w; (1,1,1)], folded to two products.
// ----------------------------------------------------------------------------
module pit3d_area #(
	parameter int COORD_BITS = pit3d_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] u [3],
	input  logic signed [COORD_BITS-1:0] v [3],
	input  logic signed [COORD_BITS-1:0] w [3],
	output logic        [2*COORD_BITS+4:0] area
);
	import pit3d_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 2;
	localparam int PW = 2 * COORD_BITS + 4;
	localparam int SW = 2 * COORD_BITS + 5;

	logic signed [DW-1:0] du [3];
	logic signed [DW-1:0] dv [3];
	logic signed [EW-1:0] ex, ey, fx, fy;
	logic signed [PW-1:0] p0, p1;
	logic signed [SW-1:0] det;

	// subtracting the z column from x and y leaves a 2x2 determinant
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			du[i] = DW'(u[i]) - DW'(w[i]);
			dv[i] = DW'(v[i]) - DW'(w[i]);
		end
		ex  = EW'(du[0]) - EW'(du[2]);
		ey  = EW'(du[1]) - EW'(du[2]);
		fx  = EW'(dv[0]) - EW'(dv[2]);
		fy  = EW'(dv[1]) - EW'(dv[2]);
		p0  = PW'(ex) * PW'(fy);
		p1  = PW'(ey) * PW'(fx);
		det = SW'(p0) - SW'(p1);
		area = det[SW-1] ? SW'(-det) : SW'(det);
	end
endmodule

// ----- rtl/core/pit3d_between.sv -----
// ----------------------------------------------------------------------------
// pit3d_between: open-segment membership
// Flags q lying strictly between u and v, checked per axis and per axis pair.
// ----------------------------------------------------------------------------
module pit3d_between #(
	parameter int COORD_BITS = pit3d_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] u [3],
	input  logic signed [COORD_BITS-1:0] v [3],
	input  logic signed [COORD_BITS-1:0] q [3],
	output logic                         hit
);
	import pit3d_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;

	logic signed [DW-1:0] d [3];
	logic signed [DW-1:0] e [3];
	logic [2:0] dz, ez, bad;
	logic signed [PW-1:0] m01, m10, m02, m20, m12, m21;
	logic xy_bad, xz_bad, yz_bad;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i]   = DW'(q[i]) - DW'(u[i]);
			e[i]   = DW'(q[i]) - DW'(v[i]);
			dz[i]  = (d[i] == '0);
			ez[i]  = (e[i] == '0);
			// zero on one side only, or both offsets on the same side
			bad[i] = (dz[i] != ez[i])
				|| (!d[i][DW-1] && !dz[i] && !e[i][DW-1] && !ez[i])
				|| (d[i][DW-1] && e[i][DW-1]);
		end
		m01 = PW'(d[0]) * PW'(e[1]);
		m10 = PW'(d[1]) * PW'(e[0]);
		m02 = PW'(d[0]) * PW'(e[2]);
		m20 = PW'(d[2]) * PW'(e[0]);
		m12 = PW'(d[1]) * PW'(e[2]);
		m21 = PW'(d[2]) * PW'(e[1]);
		xy_bad = !dz[0] && !dz[1] && (m01 != m10);
		xz_bad = !dz[0] && !dz[2] && (m02 != m20);
		yz_bad = !dz[1] && !dz[2] && (m12 != m21);
		hit = !(|bad) && !(&dz) && !xy_bad && !xz_bad && !yz_bad;
	end
endmodule

// ----- rtl/core/pit3d_eval.sv -----
// ----------------------------------------------------------------------------
// pit3d_eval: inside decision
// Combines the four areas and three segment checks into the inside flag.
// ----------------------------------------------------------------------------
module pit3d_eval #(
	parameter int COORD_BITS = pit3d_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] a [3],
	input  logic signed [COORD_BITS-1:0] b [3],
	input  logic signed [COORD_BITS-1:0] c [3],
	input  logic signed [COORD_BITS-1:0] q [3],
	output logic                         in_tri
);
	import pit3d_pkg::*;

	localparam int SW = 2 * COORD_BITS + 5;
	localparam int TW = SW + 2;

	logic [SW-1:0] whole, s1, s2, s3;
	logic [TW-1:0] sub_sum;
	logic ab_eq, ac_eq, bc_eq, qa_eq;
	logic btw_ab, btw_ac, btw_bc;

	pit3d_area #(.COORD_BITS(COORD_BITS)) u_whole (.u(a), .v(b), .w(c), .area(whole));
	pit3d_area #(.COORD_BITS(COORD_BITS)) u_s1    (.u(a), .v(b), .w(q), .area(s1));
	pit3d_area #(.COORD_BITS(COORD_BITS)) u_s2    (.u(a), .v(c), .w(q), .area(s2));
	pit3d_area #(.COORD_BITS(COORD_BITS)) u_s3    (.u(b), .v(c), .w(q), .area(s3));

	pit3d_between #(.COORD_BITS(COORD_BITS)) u_btw_ab (.u(a), .v(b), .q(q), .hit(btw_ab));
	pit3d_between #(.COORD_BITS(COORD_BITS)) u_btw_ac (.u(a), .v(c), .q(q), .hit(btw_ac));
	pit3d_between #(.COORD_BITS(COORD_BITS)) u_btw_bc (.u(b), .v(c), .q(q), .hit(btw_bc));

	always_comb begin
		ab_eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
		ac_eq = (a[0] == c[0]) && (a[1] == c[1]) && (a[2] == c[2]);
		bc_eq = (b[0] == c[0]) && (b[1] == c[1]) && (b[2] == c[2]);
		qa_eq = (q[0] == a[0]) && (q[1] == a[1]) && (q[2] == a[2]);
		sub_sum = TW'(s1) + TW'(s2) + TW'(s3);

		if (ab_eq && bc_eq) begin
			in_tri = qa_eq;
		end else if (whole == '0) begin
			// B equal to C with A apart: segment of one point, never hit
			if (ab_eq) begin
				in_tri = btw_ac;
			end else if (ac_eq) begin
				in_tri = btw_ab;
			end else if (bc_eq) begin
				in_tri = btw_bc;
			end else begin
				in_tri = btw_ab || btw_ac || btw_bc;
			end
		end else begin
			in_tri = (s1 != '0) && (s2 != '0) && (s3 != '0) && (sub_sum == TW'(whole));
		end
	end
endmodule
